[rtl/rolling_hash_pattern_matcher_top_macros.svh]
// Assertion macros shared by the checker.
`ifndef ROLLING_HASH_PATTERN_MATCHER_TOP_MACROS_SVH
`define ROLLING_HASH_PATTERN_MATCHER_TOP_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define RHPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RHPM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/rhpm_pkg.sv]
package rhpm_pkg;

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int OUT_W  = 16;
  localparam int HASH_W = 64;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_PAT   = 2'd1,
    OP_TEXT  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Multiply by the hash base 59 as 64 - 4 - 1.
  function automatic logic [HASH_W-1:0] mul_base(input logic [HASH_W-1:0] h);
    return (h << 6) - (h << 2) - h;
  endfunction

endpackage

[rtl/rhpm_if.sv]
interface rhpm_req_if;
  logic                          valid;
  logic                          ready;
  logic [rhpm_pkg::OP_W-1:0]     op;
  logic [rhpm_pkg::CHAR_W-1:0]   char_in;
  modport source (output valid, op, char_in, input ready);
  modport sink (input valid, op, char_in, output ready);
endinterface

interface rhpm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rhpm_pkg::OUT_W-1:0]    start_pos;
  logic [rhpm_pkg::OUT_W-1:0]    end_pos;
  modport source (output valid, start_pos, end_pos, input ready);
  modport sink (input valid, start_pos, end_pos, output ready);
endinterface

[rtl/rhpm_ram.sv]
module rhpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/rolling_hash_pattern_matcher_top.sv]
// One request at a time. Clear and unused op: done in S_IDLE. Pattern byte:
// the window hash is rebuilt by Horner's rule, one window byte per cycle from the
// window memory. Text byte: S_T_MUL, S_T_SUB, S_T_ROLL, S_T_SHIFT, S_T_CHK (only the
// last two with an empty pattern); on a hash hit, the byte compare (one pattern and one
// window byte per cycle) and result load, plus any wait for a stalled result register.
// Reset (rst, synchronous): empty pattern, zero hashes, power one, window reads zero.
module rolling_hash_pattern_matcher_top #(
  parameter int MAX_PATTERN = 32,
  parameter int POS_WIDTH   = 16
) (
  input logic         clk,
  input logic         rst,
  rhpm_req_if.sink    req,
  rhpm_rsp_if.source  rsp
);
  localparam int AW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int HW    = rhpm_pkg::HASH_W;
  localparam int CW    = rhpm_pkg::CHAR_W;

  typedef enum logic [3:0] {
    S_IDLE, S_H_RD, S_H_ACC, S_T_MUL, S_T_SUB, S_T_ROLL, S_T_SHIFT, S_T_CHK,
    S_C_RD, S_C_CMP, S_EMIT
  } state_t;

  state_t               state;
  logic [LEN_W-1:0]     plen;
  logic [HW-1:0]        phash, whash, lpow, prod, diff, hacc;
  logic [POS_WIDTH-1:0] tcount;
  logic [AW-1:0]        wp;
  logic [MAX_PATTERN-1:0] vld;
  logic                 rvld;
  logic [CW-1:0]        cbyte;
  logic [LEN_W-1:0]     idx;
  logic                 out_vld;
  logic [rhpm_pkg::OUT_W-1:0] out_start, out_end;

  logic [LEN_W-1:0] wlog;
  logic [AW:0]      wphys_w;
  logic [AW-1:0]    wraddr, praddr;
  logic [CW-1:0]    wrdata, prdata, wbyte;
  logic             pat_we;
  logic [HW-1:0]    hacc_next;
  logic [31:0]      start_w;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_vld;
  assign rsp.start_pos = out_start;
  assign rsp.end_pos = out_end;

  // Pick the logical window index (0 is newest) for the read issued this cycle
  always_comb begin
    case (state)
      S_IDLE:  wlog = plen - LEN_W'(1);
      S_H_RD:  wlog = idx;
      S_H_ACC: wlog = idx - LEN_W'(1);
      S_C_RD:  wlog = plen - LEN_W'(1) - idx;
      S_C_CMP: wlog = plen - LEN_W'(2) - idx;
      default: wlog = '0;
    endcase
  end

  // Map the logical index onto the circular buffer
  always_comb begin
    if ({1'b0, AW'(wlog)} < {1'b0, wp}) begin
      wphys_w = {1'b0, wp} - (AW+1)'(1) - {1'b0, AW'(wlog)};
    end else begin
      wphys_w = {1'b0, wp} + (AW+1)'(MAX_PATTERN - 1) - {1'b0, AW'(wlog)};
    end
    wraddr = AW'(wphys_w);
    praddr = (state == S_C_RD) ? AW'(idx) : AW'(idx + LEN_W'(1));
    pat_we = (state == S_IDLE) && req.valid && (req.op == rhpm_pkg::OP_PAT) &&
             (32'(plen) < MAX_PATTERN);
    wbyte = rvld ? wrdata : '0;
    hacc_next = rhpm_pkg::mul_base(hacc) + HW'(wbyte);
    start_w = 32'(tcount) - 32'(plen) + 32'd1;
  end

  rhpm_ram #(.WIDTH(CW), .DEPTH(MAX_PATTERN)) u_pat_ram (
    .clk(clk), .we(pat_we), .waddr(AW'(plen)), .wdata(req.char_in),
    .raddr(praddr), .rdata(prdata)
  );

  rhpm_ram #(.WIDTH(CW), .DEPTH(MAX_PATTERN)) u_win_ram (
    .clk(clk), .we(state == S_T_SHIFT), .waddr(wp), .wdata(cbyte),
    .raddr(wraddr), .rdata(wrdata)
  );

  // Sequencer, hash state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      plen    <= '0;
      phash   <= '0;
      whash   <= '0;
      lpow    <= HW'(1);
      tcount  <= '0;
      wp      <= '0;
      vld     <= '0;
      out_vld <= 1'b0;
    end else begin
      rvld <= vld[wraddr];
      // Drop a taken result unless a new one is loaded this cycle
      if (out_vld && rsp.ready && state != S_EMIT) begin
        out_vld <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          cbyte <= req.char_in;
          if (req.valid) begin
            case (req.op)
              rhpm_pkg::OP_CLEAR: begin
                plen   <= '0;
                phash  <= '0;
                whash  <= '0;
                lpow   <= HW'(1);
                tcount <= '0;
                wp     <= '0;
                vld    <= '0;
              end
              rhpm_pkg::OP_PAT: begin
                if (pat_we) begin
                  phash <= rhpm_pkg::mul_base(phash) + HW'(req.char_in);
                  if (plen != '0) begin
                    lpow <= rhpm_pkg::mul_base(lpow);
                  end
                  plen  <= plen + LEN_W'(1);
                  idx   <= plen;
                  hacc  <= '0;
                  state <= S_H_RD;
                end
              end
              rhpm_pkg::OP_TEXT: begin
                state <= (plen != '0) ? S_T_MUL : S_T_SHIFT;
              end
              default: ;
            endcase
          end
        end
        S_H_RD: state <= S_H_ACC;
        S_H_ACC: begin
          hacc <= hacc_next;
          if (idx == '0) begin
            whash <= hacc_next;
            state <= S_IDLE;
          end else begin
            idx <= idx - LEN_W'(1);
          end
        end
        S_T_MUL: begin
          prod  <= HW'(wbyte) * lpow;
          state <= S_T_SUB;
        end
        S_T_SUB: begin
          diff  <= whash - prod;
          state <= S_T_ROLL;
        end
        S_T_ROLL: begin
          whash <= rhpm_pkg::mul_base(diff) + HW'(cbyte);
          state <= S_T_SHIFT;
        end
        S_T_SHIFT: begin
          vld[wp] <= 1'b1;
          wp <= (32'(wp) == MAX_PATTERN - 1) ? '0 : wp + AW'(1);
          if (tcount != '1) begin
            tcount <= tcount + POS_WIDTH'(1);
          end
          state <= S_T_CHK;
        end
        S_T_CHK: begin
          idx <= '0;
          if (plen != '0 && 32'(tcount) >= 32'(plen) && whash == phash) begin
            state <= S_C_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_C_RD: state <= S_C_CMP;
        S_C_CMP: begin
          if (prdata != wrdata) begin
            state <= S_IDLE;
          end else if (idx == plen - LEN_W'(1)) begin
            state <= S_EMIT;
          end else begin
            idx <= idx + LEN_W'(1);
          end
        end
        S_EMIT: begin
          // Hold until the result register is free
          if (!out_vld || rsp.ready) begin
            out_vld   <= 1'b1;
            out_start <= start_w[rhpm_pkg::OUT_W-1:0];
            out_end   <= rhpm_pkg::OUT_W'(tcount);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/rhpm_checker.sv]
`include "rolling_hash_pattern_matcher_top_macros.svh"

module rhpm_checker #(
  parameter int MAX_PATTERN = 32
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic [rhpm_pkg::OP_W-1:0]   req_op,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [rhpm_pkg::OUT_W-1:0]  start_pos,
  input logic [rhpm_pkg::OUT_W-1:0]  end_pos
);
  // A taken text request closes the intake in the cycle after it
  `RHPM_ASSERT(a_text_busy, (req_valid && req_ready && req_op == rhpm_pkg::OP_TEXT) |=> !req_ready, "ready after text")
  // A match never spans more than the longest pattern
  `RHPM_ASSERT(a_span, rsp_valid |-> (32'(16'(end_pos - start_pos)) < MAX_PATTERN), "span")
  // A stalled result holds its payload
  `RHPM_ASSERT(a_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable({start_pos, end_pos})), "held result changed")
  // Reset leaves no result pending
  `RHPM_ASSERT_ALWAYS(a_rst, rst |=> !rsp_valid, "result after reset")
endmodule

bind rolling_hash_pattern_matcher_top rhpm_checker #(.MAX_PATTERN(MAX_PATTERN)) u_rhpm_checker (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready), .req_op(req.op),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .start_pos(rsp.start_pos), .end_pos(rsp.end_pos)
);
